[hw/rtl/tpe_pkg.sv]
// Shared widths, payload types and the saturation helper for the
// triangle plane equation pipeline. No dependencies.
package tpe_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * COORD_W + 1;
    localparam int ACC_W   = PROD_W + 2;
    localparam int CSUM_W  = COORD_W + 2;
    localparam int M_W     = 31;
    localparam int SQ_W    = 2 * M_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int LEN_W   = ROOT_W + 1;
    localparam int SCL_W   = 32;
    localparam int NUM_W   = SCL_W + M_W - 1;
    localparam int Q_W     = 33;
    localparam int DVS_W   = LEN_W + 1;
    localparam int DVD_W   = NUM_W + 2;
    localparam int NV_W    = 32;
    localparam int DOT_W   = NV_W + CSUM_W;
    localparam int T_W     = DOT_W + 2;
    localparam int HALF_W  = T_W / 2;
    localparam int PP_W    = HALF_W + SCL_W;
    localparam int PRD_W   = T_W + SCL_W;
    localparam int OFF_SHIFT = 60;

    localparam logic [SCL_W-1:0] NORMAL_SCALE_RST   = 32'h4000_0000;
    localparam logic [SCL_W-1:0] DISTANCE_SCALE_RST = 32'd357913941;

    typedef enum logic [0:0] {
        REG_NORMAL_SCALE   = 1'b0,
        REG_DISTANCE_SCALE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } t_tri;

    typedef struct packed {
        logic signed [NV_W-1:0] normal_x;
        logic signed [NV_W-1:0] normal_y;
        logic signed [NV_W-1:0] normal_z;
        logic signed [NV_W-1:0] plane_offset;
        logic                   degenerate;
    } t_plane;

    // travels with every triangle from the coordinate sums to the offset stage
    typedef struct packed {
        logic                   degen;
        logic [2:0]             neg;
        logic [2:0][CSUM_W-1:0] csum;
    } t_side;

    typedef struct packed {
        t_side               side;
        logic [2:0][M_W-1:0] m;
    } t_norm;

    typedef struct packed {
        t_side                 side;
        logic [2:0][NUM_W-1:0] num;
    } t_sq;

    typedef struct packed {
        t_side                 side;
        logic [2:0][NUM_W-1:0] num;
        logic [LEN_W-1:0]      len;
    } t_dvin;

    typedef struct packed {
        t_side                 side;
        logic [DVS_W-1:0]      d;
        logic [2:0][DVS_W-1:0] rem;
        logic [2:0][Q_W-1:0]   low;
        logic [2:0][Q_W-1:0]   q;
    } t_dvst;

    typedef struct packed {
        t_side                side;
        logic [2:0][NV_W-1:0] nv;
    } t_nvec;

    localparam logic [Q_W-1:0] SAT_NEG = Q_W'(1) << (NV_W - 1);
    localparam logic [Q_W-1:0] SAT_POS = SAT_NEG - Q_W'(1);

    // clamp a magnitude and apply the sign
    function automatic logic [NV_W-1:0] sat32(input logic [Q_W-1:0] mag, input logic neg);
        logic [Q_W-1:0] m;
        if (neg) begin
            m = (mag > SAT_NEG) ? SAT_NEG : mag;
            m = -m;
        end else begin
            m = (mag > SAT_POS) ? SAT_POS : mag;
        end
        return m[NV_W-1:0];
    endfunction

endpackage

[hw/rtl/tpe_tri_if.sv]
// Triangle request channel: valid, ready and three vertices.
// Depends on tpe_pkg.
interface tpe_tri_if;
    logic          valid;
    logic          ready;
    tpe_pkg::t_tri data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/tpe_plane_if.sv]
// Plane result channel: valid, ready, normal, offset and degenerate flag.
// Depends on tpe_pkg.
interface tpe_plane_if;
    logic            valid;
    logic            ready;
    tpe_pkg::t_plane data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/tpe_front.sv]
// Newell sums, magnitudes and block normalization to 31-bit magnitudes.
// Seven stages. Depends on tpe_pkg.
module tpe_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tpe_pkg::t_tri  i_tri,
    output logic           o_valid,
    output tpe_pkg::t_norm o_norm
);
    localparam int CW = tpe_pkg::COORD_W;
    localparam int DW = tpe_pkg::DIFF_W;
    localparam int PW = tpe_pkg::PROD_W;
    localparam int AW = tpe_pkg::ACC_W;
    localparam int SW = tpe_pkg::CSUM_W;

    logic signed [CW-1:0] w_x [3];
    logic signed [CW-1:0] w_y [3];
    logic signed [CW-1:0] w_z [3];

    logic signed [CW-1:0] r1_x [3];
    logic signed [CW-1:0] r1_y [3];
    logic signed [CW-1:0] r1_z [3];
    logic signed [DW-1:0] r1_dx [3];
    logic signed [DW-1:0] r1_dy [3];
    logic signed [DW-1:0] r1_dz [3];
    logic signed [PW-1:0] r2_px [3];
    logic signed [PW-1:0] r2_py [3];
    logic signed [PW-1:0] r2_pz [3];
    logic signed [AW-1:0] r3_acc [3];
    logic [AW-1:0] r4_mag [3];
    logic [AW-1:0] n5_mag [3];
    logic [AW-1:0] r5_mag [3];
    logic [AW-1:0] n6_mag [3];
    logic [AW-1:0] r6_mag [3];
    logic [AW-1:0] n7_mag [3];
    tpe_pkg::t_side r1_side, r2_side, r3_side, r4_side, r5_side, r6_side;
    tpe_pkg::t_norm r7_norm;
    logic [6:0] r_v;

    function automatic logic top_zero(input logic [AW-1:0] a, input logic [AW-1:0] b,
                                      input logic [AW-1:0] c, input int sh);
        return ((a | b | c) >> (AW - sh)) == '0;
    endfunction

    always_comb begin
        w_x[0] = i_tri.a_x[CW-1:0];
        w_y[0] = i_tri.a_y[CW-1:0];
        w_z[0] = i_tri.a_z[CW-1:0];
        w_x[1] = i_tri.b_x[CW-1:0];
        w_y[1] = i_tri.b_y[CW-1:0];
        w_z[1] = i_tri.b_z[CW-1:0];
        w_x[2] = i_tri.c_x[CW-1:0];
        w_y[2] = i_tri.c_y[CW-1:0];
        w_z[2] = i_tri.c_z[CW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    // stage 1: cyclic differences and coordinate sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_x[i]  <= w_x[i];
                r1_y[i]  <= w_y[i];
                r1_z[i]  <= w_z[i];
                r1_dx[i] <= DW'(w_x[(i + 1) % 3]) - DW'(w_x[(i + 2) % 3]);
                r1_dy[i] <= DW'(w_y[(i + 1) % 3]) - DW'(w_y[(i + 2) % 3]);
                r1_dz[i] <= DW'(w_z[(i + 1) % 3]) - DW'(w_z[(i + 2) % 3]);
            end
            r1_side.degen   <= 1'b0;
            r1_side.neg     <= '0;
            r1_side.csum[0] <= SW'(w_x[0]) + SW'(w_x[1]) + SW'(w_x[2]);
            r1_side.csum[1] <= SW'(w_y[0]) + SW'(w_y[1]) + SW'(w_y[2]);
            r1_side.csum[2] <= SW'(w_z[0]) + SW'(w_z[1]) + SW'(w_z[2]);
        end
    end

    // stage 2: nine products; stage 3: Newell sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r2_px[i] <= PW'(r1_y[i]) * PW'(r1_dz[i]);
                r2_py[i] <= PW'(r1_z[i]) * PW'(r1_dx[i]);
                r2_pz[i] <= PW'(r1_x[i]) * PW'(r1_dy[i]);
            end
            r2_side   <= r1_side;
            r3_acc[0] <= AW'(r2_px[0]) + AW'(r2_px[1]) + AW'(r2_px[2]);
            r3_acc[1] <= AW'(r2_py[0]) + AW'(r2_py[1]) + AW'(r2_py[2]);
            r3_acc[2] <= AW'(r2_pz[0]) + AW'(r2_pz[1]) + AW'(r2_pz[2]);
            r3_side   <= r2_side;
        end
    end

    // stage 4: sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_side.csum  <= r3_side.csum;
            r4_side.degen <= (r3_acc[0] == '0) && (r3_acc[1] == '0) && (r3_acc[2] == '0);
            for (int j = 0; j < 3; j++) begin
                r4_side.neg[j] <= r3_acc[j][AW-1];
                r4_mag[j]      <= r3_acc[j][AW-1] ? AW'(-r3_acc[j]) : AW'(r3_acc[j]);
            end
        end
    end

    // stages 5 to 7: left-justify the largest magnitude, all three alike
    always_comb begin
        n5_mag = r4_mag;
        if (top_zero(n5_mag[0], n5_mag[1], n5_mag[2], 64)) begin
            for (int j = 0; j < 3; j++) n5_mag[j] = n5_mag[j] << 64;
        end
        if (top_zero(n5_mag[0], n5_mag[1], n5_mag[2], 32)) begin
            for (int j = 0; j < 3; j++) n5_mag[j] = n5_mag[j] << 32;
        end
    end

    always_comb begin
        n6_mag = r5_mag;
        if (top_zero(n6_mag[0], n6_mag[1], n6_mag[2], 16)) begin
            for (int j = 0; j < 3; j++) n6_mag[j] = n6_mag[j] << 16;
        end
        if (top_zero(n6_mag[0], n6_mag[1], n6_mag[2], 8)) begin
            for (int j = 0; j < 3; j++) n6_mag[j] = n6_mag[j] << 8;
        end
    end

    always_comb begin
        n7_mag = r6_mag;
        if (top_zero(n7_mag[0], n7_mag[1], n7_mag[2], 4)) begin
            for (int j = 0; j < 3; j++) n7_mag[j] = n7_mag[j] << 4;
        end
        if (top_zero(n7_mag[0], n7_mag[1], n7_mag[2], 2)) begin
            for (int j = 0; j < 3; j++) n7_mag[j] = n7_mag[j] << 2;
        end
        if (top_zero(n7_mag[0], n7_mag[1], n7_mag[2], 1)) begin
            for (int j = 0; j < 3; j++) n7_mag[j] = n7_mag[j] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_mag       <= n5_mag;
            r5_side      <= r4_side;
            r6_mag       <= n6_mag;
            r6_side      <= r5_side;
            r7_norm.side <= r6_side;
            for (int j = 0; j < 3; j++) begin
                r7_norm.m[j] <= n7_mag[j][AW-1 -: tpe_pkg::M_W];
            end
        end
    end

    assign o_valid = r_v[6];
    assign o_norm  = r7_norm;

endmodule

[hw/rtl/tpe_sqrt.sv]
// Sum of squares, scaled numerators and a rounded square root, one root
// bit per stage. Depends on tpe_pkg.
module tpe_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  tpe_pkg::t_norm             i_norm,
    input  logic [tpe_pkg::SCL_W-1:0]  i_normal_scale,
    output logic                       o_valid,
    output tpe_pkg::t_dvin             o_dvin
);
    localparam int SW = tpe_pkg::SQ_W;
    localparam int RW = tpe_pkg::ROOT_W;
    localparam int NW = tpe_pkg::NUM_W;
    localparam int LW = tpe_pkg::LEN_W;
    localparam int CW = tpe_pkg::SCL_W;

    logic          w_sneg;
    logic [CW-1:0] w_smag;
    logic [NW:0]   w_num [3];

    logic [SW-1:0]  r_a_sq [3];
    tpe_pkg::t_sq   r_a_pay;
    logic           r_a_v;
    logic [SW-1:0]  r_rem  [RW+1];
    logic [SW-1:0]  r_root [RW+1];
    tpe_pkg::t_sq   r_pay  [RW+1];
    logic           r_v    [RW+1];
    tpe_pkg::t_dvin r_out;
    logic           r_out_v;

    assign w_sneg = i_normal_scale[CW-1];
    assign w_smag = w_sneg ? -i_normal_scale : i_normal_scale;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_num[j] = (NW + 1)'(w_smag) * (NW + 1)'(i_norm.m[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_v[0]  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_a_v   <= i_valid;
            r_v[0]  <= r_a_v;
            r_out_v <= r_v[RW];
        end
        if (i_en) begin
            r_a_pay.side.degen <= i_norm.side.degen;
            r_a_pay.side.csum  <= i_norm.side.csum;
            // fold the sign of the scale into each component now
            r_a_pay.side.neg   <= i_norm.side.neg ^ {3{w_sneg}};
            for (int j = 0; j < 3; j++) begin
                r_a_sq[j]      <= SW'(i_norm.m[j]) * SW'(i_norm.m[j]);
                r_a_pay.num[j] <= w_num[j][NW-1:0];
            end
            r_rem[0]  <= r_a_sq[0] + r_a_sq[1] + r_a_sq[2];
            r_root[0] <= '0;
            r_pay[0]  <= r_a_pay;
        end
    end

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * k);
        logic [SW:0] w_trial;
        logic        w_take;

        assign w_trial = {1'b0, r_root[k]} + {1'b0, BIT};
        assign w_take  = {1'b0, r_rem[k]} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= w_take ? r_rem[k] - w_trial[SW-1:0] : r_rem[k];
                r_root[k+1] <= w_take ? (r_root[k] >> 1) + BIT : r_root[k] >> 1;
                r_pay[k+1]  <= r_pay[k];
            end
        end
    end

    // round to nearest: bump when the remainder exceeds the root
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.side <= r_pay[RW].side;
            r_out.num  <= r_pay[RW].num;
            r_out.len  <= LW'(r_root[RW][RW-1:0]) + LW'(r_rem[RW] > r_root[RW]);
        end
    end

    assign o_valid = r_out_v;
    assign o_dvin  = r_out;

endmodule

[hw/rtl/tpe_div.sv]
// Three rounded quotients over a shared divisor, one quotient bit per
// stage, then saturation to Q2.30. Depends on tpe_pkg.
module tpe_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tpe_pkg::t_dvin i_dvin,
    output logic           o_valid,
    output tpe_pkg::t_nvec o_nvec
);
    localparam int QW = tpe_pkg::Q_W;
    localparam int DW = tpe_pkg::DVS_W;
    localparam int NW = tpe_pkg::DVD_W;

    logic [NW-1:0]   w_n [3];
    tpe_pkg::t_dvst  r_st [QW+1];
    logic            r_v  [QW+1];
    tpe_pkg::t_nvec  r_out;
    logic            r_out_v;

    // numerator 2*num + len, divisor 2*len
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_n[j] = {1'b0, i_dvin.num[j], 1'b0} + NW'(i_dvin.len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0]  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_v[0]  <= i_valid;
            r_out_v <= r_v[QW];
        end
        if (i_en) begin
            r_st[0].side <= i_dvin.side;
            r_st[0].d    <= {i_dvin.len, 1'b0};
            for (int j = 0; j < 3; j++) begin
                r_st[0].rem[j] <= DW'(w_n[j][NW-1:QW]);
                r_st[0].low[j] <= w_n[j][QW-1:0];
                r_st[0].q[j]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0] w_t [3];
        logic [2:0]  w_take;

        always_comb begin
            for (int j = 0; j < 3; j++) begin
                w_t[j]    = {r_st[k].rem[j], r_st[k].low[j][QW-1]};
                w_take[j] = w_t[j] >= {1'b0, r_st[k].d};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_st[k+1].side <= r_st[k].side;
                r_st[k+1].d    <= r_st[k].d;
                for (int j = 0; j < 3; j++) begin
                    r_st[k+1].rem[j] <= w_take[j] ? DW'(w_t[j] - {1'b0, r_st[k].d})
                                                  : w_t[j][DW-1:0];
                    r_st[k+1].low[j] <= r_st[k].low[j] << 1;
                    r_st[k+1].q[j]   <= {r_st[k].q[j][QW-2:0], w_take[j]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.side <= r_st[QW].side;
            for (int j = 0; j < 3; j++) begin
                r_out.nv[j] <= r_st[QW].side.degen ? '0
                             : tpe_pkg::sat32(r_st[QW].q[j], r_st[QW].side.neg[j]);
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_nvec  = r_out;

endmodule

[hw/rtl/tpe_offset.sv]
// Plane offset: dot products with the coordinate sums, distance scale,
// rounding and saturation; drives the result register. Depends on tpe_pkg.
module tpe_offset (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  tpe_pkg::t_nvec            i_nvec,
    input  logic [tpe_pkg::SCL_W-1:0] i_distance_scale,
    output logic                      o_valid,
    output tpe_pkg::t_plane           o_plane
);
    localparam int DW = tpe_pkg::DOT_W;
    localparam int TW = tpe_pkg::T_W;
    localparam int HW = tpe_pkg::HALF_W;
    localparam int PW = tpe_pkg::PP_W;
    localparam int RW = tpe_pkg::PRD_W;
    localparam int CW = tpe_pkg::SCL_W;
    localparam int SH = tpe_pkg::OFF_SHIFT;
    localparam logic [RW-1:0] RND = RW'(1) << (SH - 1);

    logic          w_dneg;
    logic [CW-1:0] w_dmag;
    logic [RW-1:0] w_prod;
    logic [CW-1:0] w_r;

    logic signed [DW-1:0] r1_dot [3];
    logic signed [TW-1:0] r2_t;
    logic [TW-1:0]        r3_tm;
    logic                 r3_tneg;
    logic [PW-1:0]        r4_plo;
    logic [PW-1:0]        r4_phi;
    logic                 r4_neg;
    tpe_pkg::t_nvec       r1_nv, r2_nv, r3_nv, r4_nv;
    tpe_pkg::t_plane      r5_out;
    logic [4:0]           r_v;

    assign w_dneg = i_distance_scale[CW-1];
    assign w_dmag = w_dneg ? -i_distance_scale : i_distance_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r1_dot[j] <= DW'($signed(i_nvec.nv[j])) * DW'($signed(i_nvec.side.csum[j]));
            end
            r1_nv   <= i_nvec;
            r2_t    <= TW'(r1_dot[0]) + TW'(r1_dot[1]) + TW'(r1_dot[2]);
            r2_nv   <= r1_nv;
            r3_tneg <= r2_t[TW-1];
            r3_tm   <= r2_t[TW-1] ? TW'(-r2_t) : TW'(r2_t);
            r3_nv   <= r2_nv;
            // split the wide magnitude into two partial products
            r4_plo  <= PW'(r3_tm[HW-1:0]) * PW'(w_dmag);
            r4_phi  <= PW'(r3_tm[TW-1:HW]) * PW'(w_dmag);
            r4_neg  <= r3_tneg ^ w_dneg;
            r4_nv   <= r3_nv;
        end
    end

    assign w_prod = RW'(r4_plo) + (RW'(r4_phi) << HW) + RND;
    assign w_r    = (w_prod[RW-1:SH+CW] != '0) ? '1 : w_prod[SH+CW-1:SH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_out.normal_x     <= r4_nv.nv[0];
            r5_out.normal_y     <= r4_nv.nv[1];
            r5_out.normal_z     <= r4_nv.nv[2];
            r5_out.plane_offset <= r4_nv.side.degen ? '0
                                 : tpe_pkg::sat32({1'b0, w_r}, r4_neg);
            r5_out.degenerate   <= r4_nv.side.degen;
        end
    end

    assign o_valid = r_v[4];
    assign o_plane = r5_out;

endmodule

[hw/rtl/triangle_plane_equation.sv]
// Top level of the triangle plane equation pipeline: configuration
// registers, stall control and the four pipeline sections.
// Depends on tpe_pkg, tpe_tri_if, tpe_plane_if and the tpe_* sections.
//
//   channel   dir  handshake      payload
//   i_tri     in   valid/ready    a_x..c_z, nine Q16.16 coordinates
//   o_plane   out  valid/ready    normal_x/y/z Q2.30, plane_offset, degenerate
//   cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data (32 bits)
//
// One triangle per cycle while results are taken; the square root yields one
// root bit per stage and the divider one quotient bit per stage.
// Reset clears all valid bits and loads the default scales.
// A held result freezes every stage together; nothing is dropped or repeated.
module triangle_plane_equation (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tpe_tri_if.sink                   i_tri,
    tpe_plane_if.source               o_plane,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [tpe_pkg::SCL_W-1:0] i_cfg_data
);
    logic [tpe_pkg::SCL_W-1:0] r_normal_scale;
    logic [tpe_pkg::SCL_W-1:0] r_distance_scale;

    logic            w_en;
    logic            w_front_v, w_sqrt_v, w_div_v, w_off_v;
    tpe_pkg::t_norm  w_norm;
    tpe_pkg::t_dvin  w_dvin;
    tpe_pkg::t_nvec  w_nvec;
    tpe_pkg::t_plane w_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normal_scale   <= tpe_pkg::NORMAL_SCALE_RST;
            r_distance_scale <= tpe_pkg::DISTANCE_SCALE_RST;
        end else if (i_cfg_we) begin
            case (tpe_pkg::t_reg_idx'(i_cfg_idx))
                tpe_pkg::REG_NORMAL_SCALE: begin
                    r_normal_scale <= i_cfg_data;
                end
                tpe_pkg::REG_DISTANCE_SCALE: begin
                    r_distance_scale <= i_cfg_data;
                end
                default: begin
                    r_normal_scale <= r_normal_scale;
                end
            endcase
        end
    end

    // advance everything unless the result register holds an untaken result
    assign w_en        = !w_off_v || o_plane.ready;
    assign i_tri.ready = w_en;

    tpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_tri.valid),
        .i_tri   (i_tri.data),
        .o_valid (w_front_v),
        .o_norm  (w_norm)
    );

    tpe_sqrt u_sqrt (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_front_v),
        .i_norm         (w_norm),
        .i_normal_scale (r_normal_scale),
        .o_valid        (w_sqrt_v),
        .o_dvin         (w_dvin)
    );

    tpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sqrt_v),
        .i_dvin  (w_dvin),
        .o_valid (w_div_v),
        .o_nvec  (w_nvec)
    );

    tpe_offset u_offset (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_valid          (w_div_v),
        .i_nvec           (w_nvec),
        .i_distance_scale (r_distance_scale),
        .o_valid          (w_off_v),
        .o_plane          (w_plane)
    );

    assign o_plane.valid = w_off_v;
    assign o_plane.data  = w_plane;

endmodule
